@@ src/quaternion_vector_rotate_top_defines.svh @@
// assertion macros for the quaternion vector rotation block
// used by quaternion_vector_rotate_top; expects a clk and rst in scope
`ifndef QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH

// checked on every rising edge outside of reset
`define QVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define QVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/qvr_pkg.sv @@
// shared types and constants for the quaternion vector rotation block
// no dependencies
package qvr_pkg;

  // configuration register index
  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_QUAT_REAL = 2'd0,
    REG_QUAT_I    = 2'd1,
    REG_QUAT_J    = 2'd2,
    REG_QUAT_K    = 2'd3
  } cfg_reg_t;

  // vector components per item
  localparam int NUM_AXES = 3;

  // pipeline depth from input register to output register
  localparam int NUM_STAGES = 5;

endpackage

@@ src/qvr_mul_rnd.sv @@
// signed multiply with round-to-nearest rescale and a registered result
// no dependencies
module qvr_mul_rnd #(
  parameter int A_WIDTH   = 18,
  parameter int B_WIDTH   = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic signed [A_WIDTH-1:0]                a,
  input  logic signed [B_WIDTH-1:0]                b,
  output logic signed [A_WIDTH+B_WIDTH-FRAC_BITS-1:0] prod
);

  localparam int P_WIDTH = A_WIDTH + B_WIDTH;
  localparam logic signed [P_WIDTH-1:0] HALF = P_WIDTH'(1) << (FRAC_BITS - 1);

  logic signed [P_WIDTH-1:0] full;
  logic signed [P_WIDTH-1:0] rounded;

  // exact product, then add half an lsb so the shift rounds ties upward
  assign full    = a * b;
  assign rounded = full + HALF;

  // arithmetic shift by the fraction bits, held while the stage stalls
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= rounded[P_WIDTH-1:FRAC_BITS];
    end
  end

endmodule

@@ src/quaternion_vector_rotate_top.sv @@
// quaternion vector rotation: r = a + 2w(q x a) + 2 q x (q x a), fixed point
// depends on qvr_pkg, qvr_mul_rnd and quaternion_vector_rotate_top_defines.svh
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_stall, vec_x/y/z    | into block
//   output  | out_valid, out_stall, rot_x/y/z, | out of block
//           | clipped                          |
//   config  | cfg_we, cfg_index, cfg_data      | into block
//
// five register stages; one transfer per cycle unless out_stall backs up the stages
// stages: q x a products, cross difference, q x c and 2w*c products,
//   second cross difference, sum and saturate into the output register
// rst is synchronous and clears the valid bits and loads the identity quaternion
// out_stall backs up through the stages; in_stall rises only when all five are full
`include "quaternion_vector_rotate_top_defines.svh"

module quaternion_vector_rotate_top #(
  parameter int COORD_WIDTH    = 32,
  parameter int QUAT_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration writes
  input  logic                                   cfg_we,
  input  logic [qvr_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [QUAT_FRAC_BITS+1:0]              cfg_data,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_WIDTH-1:0]          vec_x,
  input  logic signed [COORD_WIDTH-1:0]          vec_y,
  input  logic signed [COORD_WIDTH-1:0]          vec_z,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [COORD_WIDTH-1:0]          rot_x,
  output logic signed [COORD_WIDTH-1:0]          rot_y,
  output logic signed [COORD_WIDTH-1:0]          rot_z,
  output logic                                   clipped
);

  import qvr_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = QUAT_FRAC_BITS;
  localparam int QW = F + 2;
  // q * a rescaled, then cross difference
  localparam int R1  = QW + CW - F;
  localparam int CWD = R1 + 1;
  // q * c and 2w * c rescaled, then cross difference
  localparam int R2 = QW + CWD - F;
  localparam int R3 = QW + 1 + CWD - F;
  localparam int DW = R2 + 1;
  // final sum before saturation
  localparam int SW = R3 + 3;

  localparam logic [QW-1:0] QUAT_ONE = QW'(1) << F;
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // quaternion registers
  logic signed [QW-1:0] quat_real;
  logic signed [QW-1:0] quat_v [NUM_AXES];
  logic signed [QW:0]   w2;

  // pipeline control
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] stage_ready;

  // datapath
  logic signed [CW-1:0]  vec_in [NUM_AXES];
  logic signed [CW-1:0]  vec_a  [NUM_AXES];
  logic signed [CW-1:0]  vec_b  [NUM_AXES];
  logic signed [CW-1:0]  vec_c  [NUM_AXES];
  logic signed [CW-1:0]  vec_d  [NUM_AXES];
  logic signed [R1-1:0]  pa     [NUM_AXES];
  logic signed [R1-1:0]  pb     [NUM_AXES];
  logic signed [CWD-1:0] cross_b [NUM_AXES];
  logic signed [R2-1:0]  qa     [NUM_AXES];
  logic signed [R2-1:0]  qb     [NUM_AXES];
  logic signed [R3-1:0]  wc_c   [NUM_AXES];
  logic signed [R3-1:0]  wc_d   [NUM_AXES];
  logic signed [DW-1:0]  dbl_d  [NUM_AXES];
  logic signed [SW-1:0]  sum    [NUM_AXES];
  logic [NUM_AXES-1:0]   ovf;
  logic signed [CW-1:0]  rot_next [NUM_AXES];
  logic signed [CW-1:0]  rot    [NUM_AXES];
  logic                  rot_sat;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      quat_real <= QUAT_ONE;
      quat_v[0] <= '0;
      quat_v[1] <= '0;
      quat_v[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_QUAT_REAL: quat_real <= cfg_data;
        REG_QUAT_I:    quat_v[0] <= cfg_data;
        REG_QUAT_J:    quat_v[1] <= cfg_data;
        REG_QUAT_K:    quat_v[2] <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign w2 = {quat_real, 1'b0};

  // a stage can load when it is empty or its contents move on
  always_comb begin
    stage_ready[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  assign in_stall  = !stage_ready[0];
  assign out_valid = stage_valid[NUM_STAGES-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign vec_in[0] = vec_x;
  assign vec_in[1] = vec_y;
  assign vec_in[2] = vec_z;

  // per-axis multipliers: both cross products and the 2w scaling
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    localparam int J = (i + 1) % NUM_AXES;
    localparam int K = (i + 2) % NUM_AXES;

    qvr_mul_rnd #(.A_WIDTH(QW), .B_WIDTH(CW), .FRAC_BITS(F)) u_pa (
      .clk (clk), .en (stage_ready[0]), .a (quat_v[J]), .b (vec_in[K]), .prod (pa[i])
    );
    qvr_mul_rnd #(.A_WIDTH(QW), .B_WIDTH(CW), .FRAC_BITS(F)) u_pb (
      .clk (clk), .en (stage_ready[0]), .a (quat_v[K]), .b (vec_in[J]), .prod (pb[i])
    );
    qvr_mul_rnd #(.A_WIDTH(QW), .B_WIDTH(CWD), .FRAC_BITS(F)) u_qa (
      .clk (clk), .en (stage_ready[2]), .a (quat_v[J]), .b (cross_b[K]), .prod (qa[i])
    );
    qvr_mul_rnd #(.A_WIDTH(QW), .B_WIDTH(CWD), .FRAC_BITS(F)) u_qb (
      .clk (clk), .en (stage_ready[2]), .a (quat_v[K]), .b (cross_b[J]), .prod (qb[i])
    );
    qvr_mul_rnd #(.A_WIDTH(QW + 1), .B_WIDTH(CWD), .FRAC_BITS(F)) u_wc (
      .clk (clk), .en (stage_ready[2]), .a (w2), .b (cross_b[i]), .prod (wc_c[i])
    );

    // final sum with every term sign-extended to the sum width
    assign sum[i] = $signed({{(SW-CW){vec_d[i][CW-1]}}, vec_d[i]})
                  + $signed({{(SW-R3){wc_d[i][R3-1]}}, wc_d[i]})
                  + $signed({{(SW-DW-1){dbl_d[i][DW-1]}}, dbl_d[i], 1'b0});

    // out of range when the bits above the output width disagree with the sign
    assign ovf[i] = !((&sum[i][SW-1:CW-1]) || !(|sum[i][SW-1:CW-1]));
    assign rot_next[i] = ovf[i] ? (sum[i][SW-1] ? SAT_MIN : SAT_MAX) : sum[i][CW-1:0];
  end

  // datapath registers, each held while its stage stalls
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (stage_ready[0]) begin
        vec_a[i] <= vec_in[i];
      end
      if (stage_ready[1]) begin
        vec_b[i]   <= vec_a[i];
        cross_b[i] <= {pa[i][R1-1], pa[i]} - {pb[i][R1-1], pb[i]};
      end
      if (stage_ready[2]) begin
        vec_c[i] <= vec_b[i];
      end
      if (stage_ready[3]) begin
        vec_d[i] <= vec_c[i];
        wc_d[i]  <= wc_c[i];
        dbl_d[i] <= {qa[i][R2-1], qa[i]} - {qb[i][R2-1], qb[i]};
      end
      if (stage_ready[4]) begin
        rot[i] <= rot_next[i];
      end
    end
    if (stage_ready[4]) begin
      clipped <= |ovf;
    end
  end

  assign rot_x = rot[0];
  assign rot_y = rot[1];
  assign rot_z = rot[2];

  // some output component sits at a saturation limit
  assign rot_sat = (rot_x == SAT_MAX) || (rot_x == SAT_MIN)
                || (rot_y == SAT_MAX) || (rot_y == SAT_MIN)
                || (rot_z == SAT_MAX) || (rot_z == SAT_MIN);

  // a clipped result carries a saturated value in at least one component
  `QVR_ASSERT(a_clip_saturated, out_valid && clipped |-> rot_sat, "clipped without saturation")

  // input backs up only when every stage holds an item
  `QVR_ASSERT(a_stall_full, in_stall |-> (&stage_valid), "input stalled with an empty stage")

  // reset empties the pipeline and restores the identity quaternion
  `QVR_ASSERT_ALWAYS(a_reset_state, rst |=> !out_valid && quat_real == QUAT_ONE, "bad reset state")

endmodule

@@ tb/quaternion_vector_rotate_top_test.sv @@
// self-checking testbench for quaternion_vector_rotate_top
// depends on qvr_pkg and the rotation block; predicts each rotated vector in fixed point
`timescale 1ns / 1ps

module quaternion_vector_rotate_top_test;
  import qvr_pkg::*;

  localparam int COORD_WIDTH    = 32;
  localparam int QUAT_FRAC_BITS = 16;
  localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;
  localparam longint COORD_MAX  = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN  = -COORD_MAX - 1;
  localparam longint ROUND_HALF = 64'sd1 <<< (QUAT_FRAC_BITS - 1);
  localparam logic signed [COORD_WIDTH-1:0] CMAX = COORD_WIDTH'(COORD_MAX);
  localparam logic signed [COORD_WIDTH-1:0] CMIN = COORD_WIDTH'(COORD_MIN);
  localparam logic signed [QUAT_WIDTH-1:0] QONE = QUAT_WIDTH'(1) <<< QUAT_FRAC_BITS;
  localparam int RANDOM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE  = 190;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          clip;
  } rot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_QUAT_REAL;
  logic [QUAT_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_WIDTH-1:0] vec_x = '0;
  logic signed [COORD_WIDTH-1:0] vec_y = '0;
  logic signed [COORD_WIDTH-1:0] vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_WIDTH-1:0] rot_x;
  logic signed [COORD_WIDTH-1:0] rot_y;
  logic signed [COORD_WIDTH-1:0] rot_z;
  logic clipped;

  // predictor copy of the quaternion registers
  logic signed [QUAT_WIDTH-1:0] quat_w = QONE;
  logic signed [QUAT_WIDTH-1:0] quat_i = '0;
  logic signed [QUAT_WIDTH-1:0] quat_j = '0;
  logic signed [QUAT_WIDTH-1:0] quat_k = '0;

  vec_t pending_vecs[$];
  rot_t expected_rots[$];
  int   queued_count = 0;
  int   accepted_count = 0;
  int   mismatches = 0;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  logic long_hold_go = 1'b0;
  logic long_hold = 1'b0;

  quaternion_vector_rotate_top #(
    .COORD_WIDTH   (COORD_WIDTH),
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rot_x    (rot_x),
    .rot_y    (rot_y),
    .rot_z    (rot_z),
    .clipped  (clipped)
  );

  always #10 clk = ~clk;

  // exact product, rescaled with round half up
  function automatic longint scale_mul(longint a, longint b);
    longint p;
    p = a * b;
    return (p + ROUND_HALF) >>> QUAT_FRAC_BITS;
  endfunction

  // a + 2w (q x a) + 2 q x (q x a), each component saturated
  function automatic rot_t rotate_vec(vec_t v);
    longint a[3];
    longint q[3];
    longint c[3];
    longint d[3];
    longint s;
    longint two_w;
    logic signed [COORD_WIDTH-1:0] r[3];
    rot_t res;
    a[0] = longint'(v.x);
    a[1] = longint'(v.y);
    a[2] = longint'(v.z);
    q[0] = longint'(quat_i);
    q[1] = longint'(quat_j);
    q[2] = longint'(quat_k);
    two_w = 2 * longint'(quat_w);
    for (int k = 0; k < 3; k++)
      c[k] = scale_mul(q[(k+1)%3], a[(k+2)%3]) - scale_mul(q[(k+2)%3], a[(k+1)%3]);
    for (int k = 0; k < 3; k++)
      d[k] = scale_mul(q[(k+1)%3], c[(k+2)%3]) - scale_mul(q[(k+2)%3], c[(k+1)%3]);
    res.clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      s = a[k] + scale_mul(two_w, c[k]) + 2 * d[k];
      if (s > COORD_MAX) begin
        s = COORD_MAX;
        res.clip = 1'b1;
      end else if (s < COORD_MIN) begin
        s = COORD_MIN;
        res.clip = 1'b1;
      end
      r[k] = COORD_WIDTH'(s);
    end
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    return res;
  endfunction

  // input driver: presents queued vectors, records the prediction on each transfer
  always @(posedge clk) begin
    vec_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rots.push_back(rotate_vec('{vec_x, vec_y, vec_z}));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
          gap_left = $urandom_range(15, 1);
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_vecs.size() != 0) begin
          nxt = pending_vecs.pop_front();
          in_valid <= 1'b1;
          vec_x <= nxt.x;
          vec_y <= nxt.y;
          vec_z <= nxt.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: compares each transfer against the oldest prediction
  always @(posedge clk) begin
    rot_t want;
    rot_t got;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{rot_x, rot_y, rot_z, clipped};
        if (expected_rots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: x=%0d y=%0d z=%0d clipped=%0b",
                     got.x, got.y, got.z, got.clip);
        end else begin
          want = expected_rots.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected x=%0d y=%0d z=%0d clipped=%0b, ",
                        "got x=%0d y=%0d z=%0d clipped=%0b"},
                       want.x, want.y, want.z, want.clip,
                       got.x, got.y, got.z, got.clip);
          end
        end
      end
      if (stall_left > 0)
        stall_left--;
      else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct)
        stall_left = $urandom_range(15, 1);
      out_stall <= long_hold || (stall_left > 0);
    end
  end

  // long receiver hold-off so the pipeline fills and stalls its input
  initial begin
    wait (long_hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic push_vec(input logic signed [COORD_WIDTH-1:0] x, y, z);
    pending_vecs.push_back('{x, y, z});
    queued_count++;
  endtask

  // blocks until every queued vector has transferred and every result is back
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_rots.size() != 0)
      @(posedge clk);
  endtask

  // write all four quaternion registers, one per cycle, while the block is idle
  task automatic load_quat(input logic signed [QUAT_WIDTH-1:0] w, qi, qj, qk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_QUAT_REAL;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_QUAT_I;
    cfg_data  <= qi;
    @(posedge clk);
    cfg_index <= REG_QUAT_J;
    cfg_data  <= qj;
    @(posedge clk);
    cfg_index <= REG_QUAT_K;
    cfg_data  <= qk;
    @(posedge clk);
    cfg_we <= 1'b0;
    quat_w = w;
    quat_i = qi;
    quat_j = qj;
    quat_k = qk;
  endtask

  // mostly near-unit rotations, some in the +-1.0 range, some full register width
  task automatic load_random_quat();
    real comp[4];
    real norm;
    logic signed [QUAT_WIDTH-1:0] v[4];
    int mode;
    mode = $urandom_range(3);
    if (mode < 2) begin
      norm = 1.0e-3;
      for (int n = 0; n < 4; n++) begin
        comp[n] = real'($urandom_range(2000)) - 1000.0;
        norm += comp[n] * comp[n];
      end
      norm = $sqrt(norm);
      for (int n = 0; n < 4; n++)
        v[n] = QUAT_WIDTH'($rtoi(comp[n] * 65536.0 / norm));
    end else if (mode == 2) begin
      for (int n = 0; n < 4; n++)
        v[n] = QUAT_WIDTH'(int'($urandom_range(131072)) - 65536);
    end else begin
      for (int n = 0; n < 4; n++)
        v[n] = QUAT_WIDTH'($urandom);
    end
    load_quat(v[0], v[1], v[2], v[3]);
  endtask

  // extremes and -1, 0 or +1 now and then, otherwise random with a random magnitude
  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(9))
      0: return CMAX;
      1: return CMIN;
      2: return COORD_WIDTH'(int'($urandom_range(2)) - 1);
      default: return $signed(COORD_WIDTH'($urandom)) >>> $urandom_range(24);
    endcase
  endfunction

  // stimulus sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct = 20;
    recv_stall_pct = 20;

    // identity after reset
    push_vec(0, 0, 0);
    push_vec(CMAX, CMIN, 1);
    push_vec(CMIN, CMAX, -1);
    push_vec(32'sh8000, -32'sh8000, 32'sh10000);
    wait_drained();

    // half turn about x
    load_quat(0, QONE, 0, 0);
    push_vec(CMAX, CMAX, CMAX);
    push_vec(CMIN, CMIN, CMIN);
    push_vec(1, -1, 32'sh8000);
    wait_drained();

    // quarter turn about z
    load_quat(46341, 0, 0, 46341);
    push_vec(32'sh10000, 0, 0);
    push_vec(CMAX, CMIN, 0);
    wait_drained();

    // non-unit quaternion at the top of the register range
    load_quat(18'sh1ffff, 18'sh1ffff, 18'sh1ffff, 18'sh1ffff);
    push_vec(CMAX, CMIN, CMAX);
    push_vec(1, 2, 3);
    wait_drained();

    // bottom of the register range
    load_quat(-18'sh20000, -18'sh20000, -18'sh20000, -18'sh20000);
    push_vec(CMIN, CMIN, CMIN);
    push_vec(CMAX, CMAX, CMAX);
    wait_drained();

    // tiny quaternion so products land on rounding ties
    load_quat(1, 1, 1, 1);
    push_vec(32'sh8000, 32'sh8000, -32'sh8000);
    push_vec(32'sh18000, -32'sh8000, 32'sh8000);
    wait_drained();

    // +-1.0 in every register
    load_quat(-QONE, QONE, -QONE, QONE);
    push_vec(32'sh12345678, -32'sh0badcafe, 7);
    wait_drained();

    // random phases, each under a new quaternion
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_random_quat();
      if (p == 2 || p >= RANDOM_PHASES - 2) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end else if (p == 4) begin
        send_gap_pct = 0;
        recv_stall_pct = 10;
        long_hold_go = 1'b1;
      end else begin
        send_gap_pct = $urandom_range(40, 5);
        recv_stall_pct = $urandom_range(40, 5);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        push_vec(rand_coord(), rand_coord(), rand_coord());
      wait_drained();
    end

    repeat (4 * NUM_STAGES) @(posedge clk);
    if (mismatches == 0 && expected_rots.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
